// File: rtl/core/x86mad_pkg.sv
`default_nettype none

package x86mad_pkg;

	typedef enum logic [2:0] {
		KIND_UNKNOWN,
		KIND_REGMEM,
		KIND_IMMREG,
		KIND_MOVIMM,
		KIND_GROUP
	} kind_t;

	localparam logic [2:0] OPER_MOV   = 3'd0;
	localparam logic [2:0] OPER_ADD   = 3'd1;
	localparam logic [2:0] OPER_SUB   = 3'd2;
	localparam logic [2:0] OPER_CMP   = 3'd3;
	localparam logic [2:0] OPER_OTHER = 3'd4;

	localparam logic [1:0] FORM_REG_RM  = 2'd0;
	localparam logic [1:0] FORM_IMM_REG = 2'd1;
	localparam logic [1:0] FORM_IMM_RM  = 2'd2;

	localparam logic [2:0] GRP_ADD = 3'd0;
	localparam logic [2:0] GRP_SUB = 3'd5;
	localparam logic [2:0] GRP_CMP = 3'd7;
	localparam logic [2:0] RM_DIRECT = 3'd6;

	localparam logic [7:0] OPC_GROUP_W    = 8'h81;
	localparam logic [7:0] OPC_GROUP_SEXT = 8'h83;

	localparam logic [1:0] MOD_MEM    = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;

	localparam logic [2:0] COUNT_MAX = 3'd7;

	typedef struct packed {
		logic        status;
		logic [2:0]  operation;
		logic [1:0]  form;
		logic        wide;
		logic        to_reg;
		logic [1:0]  mode;
		logic [2:0]  reg_sel;
		logic [2:0]  rm_sel;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
		logic [7:0]  first_byte;
	} rec_t;

	function automatic kind_t kind_of(input logic [7:0] op);
		kind_t k;
		k = KIND_UNKNOWN;
		if (op[7:2] == 6'b100010) begin
			k = KIND_REGMEM;
		end else if (op[7:4] == 4'hB) begin
			k = KIND_IMMREG;
		end else if (op[7:1] == 7'b1100011) begin
			k = KIND_MOVIMM;
		end else if (op[7:2] == 6'b100000) begin
			k = KIND_GROUP;
		end
		return k;
	endfunction

	// Number of displacement bytes that follow the addressing byte.
	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		logic [1:0] n;
		n = 2'd0;
		if (modrm[7:6] == MOD_DISP8) begin
			n = 2'd1;
		end else if (modrm[7:6] == MOD_DISP16) begin
			n = 2'd2;
		end else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) begin
			n = 2'd2;
		end
		return n;
	endfunction

	function automatic logic [1:0] imm_len(input logic [7:0] op);
		logic [1:0] n;
		n = 2'd0;
		unique case (kind_of(op))
			KIND_IMMREG: n = op[3] ? 2'd2 : 2'd1;
			KIND_MOVIMM: n = op[0] ? 2'd2 : 2'd1;
			KIND_GROUP:  n = (op == OPC_GROUP_W) ? 2'd2 : 2'd1;
			default:     n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] sext8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	function automatic rec_t make_rec(
		input logic [7:0]  op,
		input logic [7:0]  am,
		input logic [15:0] disp,
		input logic [15:0] imm,
		input logic [2:0]  count
	);
		rec_t  r;
		kind_t k;
		k = kind_of(op);
		r.status       = 1'b0;
		r.operation    = OPER_MOV;
		r.form         = FORM_IMM_RM;
		r.wide         = op[0];
		r.to_reg       = 1'b0;
		r.mode         = am[7:6];
		r.reg_sel      = am[5:3];
		r.rm_sel       = am[2:0];
		r.displacement = disp;
		r.immediate    = imm;
		r.length       = count;
		r.first_byte   = op;
		if (k == KIND_REGMEM) begin
			r.form   = FORM_REG_RM;
			r.to_reg = op[1];
		end else if (k == KIND_IMMREG) begin
			r.form    = FORM_IMM_REG;
			r.wide    = op[3];
			r.to_reg  = 1'b1;
			r.mode    = 2'd0;
			r.rm_sel  = 3'd0;
			r.reg_sel = op[2:0];
		end else if (k == KIND_GROUP) begin
			if (am[5:3] == GRP_ADD) begin
				r.operation = OPER_ADD;
			end else if (am[5:3] == GRP_SUB) begin
				r.operation = OPER_SUB;
			end else if (am[5:3] == GRP_CMP) begin
				r.operation = OPER_CMP;
			end else begin
				r.operation = OPER_OTHER;
			end
		end
		return r;
	endfunction

	function automatic rec_t error_rec(input logic [7:0] op);
		rec_t r;
		r            = '0;
		r.status     = 1'b1;
		r.length     = 3'd1;
		r.first_byte = op;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/x86mad_decode.sv
`default_nettype none

module x86mad_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [7:0]        code_byte,
	output x86mad_pkg::rec_t       rec,
	output logic                   emit
);
	import x86mad_pkg::*;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_MODRM,
		PH_DISP_LO,
		PH_DISP_HI,
		PH_IMM_LO,
		PH_IMM_HI
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  opcode_q, opcode_n;
	logic [7:0]  modrm_q, modrm_n;
	logic [15:0] disp_q, disp_n;
	logic [15:0] imm_q, imm_n;
	logic [2:0]  count_q, count_n;
	logic        halted_q, halted_n;
	logic        done, fail;
	logic        need_imm;

	always_comb begin
		phase_n  = phase_q;
		opcode_n = opcode_q;
		modrm_n  = modrm_q;
		disp_n   = disp_q;
		imm_n    = imm_q;
		count_n  = (count_q < COUNT_MAX) ? count_q + 3'd1 : count_q;
		halted_n = halted_q;
		done     = 1'b0;
		fail     = 1'b0;
		need_imm = imm_len(opcode_q) != 2'd0;
		unique case (phase_q)
			PH_MODRM: begin
				modrm_n = code_byte;
				if (disp_len(code_byte) != 2'd0) begin
					phase_n = PH_DISP_LO;
				end else if (need_imm) begin
					phase_n = PH_IMM_LO;
				end else begin
					done = 1'b1;
				end
			end
			PH_DISP_LO: begin
				if (disp_len(modrm_q) == 2'd2) begin
					disp_n  = {8'h00, code_byte};
					phase_n = PH_DISP_HI;
				end else begin
					disp_n = sext8(code_byte);
					if (need_imm) begin
						phase_n = PH_IMM_LO;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_DISP_HI: begin
				disp_n = {code_byte, disp_q[7:0]};
				if (need_imm) begin
					phase_n = PH_IMM_LO;
				end else begin
					done = 1'b1;
				end
			end
			PH_IMM_LO: begin
				if (imm_len(opcode_q) == 2'd2) begin
					imm_n   = {8'h00, code_byte};
					phase_n = PH_IMM_HI;
				end else begin
					imm_n = (opcode_q == OPC_GROUP_SEXT) ? sext8(code_byte)
						: {8'h00, code_byte};
					done  = 1'b1;
				end
			end
			PH_IMM_HI: begin
				imm_n = {code_byte, imm_q[7:0]};
				done  = 1'b1;
			end
			default: begin
				opcode_n = code_byte;
				modrm_n  = 8'h00;
				disp_n   = 16'h0000;
				imm_n    = 16'h0000;
				count_n  = 3'd1;
				unique case (kind_of(code_byte))
					KIND_UNKNOWN: begin
						halted_n = 1'b1;
						fail     = 1'b1;
					end
					KIND_IMMREG: phase_n = PH_IMM_LO;
					default:     phase_n = PH_MODRM;
				endcase
			end
		endcase
		if (done) begin
			phase_n = PH_OPCODE;
		end
	end

	assign emit = en && !halted_q && (done || fail);
	assign rec  = fail ? error_rec(code_byte)
		: make_rec(opcode_n, modrm_n, disp_n, imm_n, count_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			opcode_q <= 8'h00;
			modrm_q  <= 8'h00;
			disp_q   <= 16'h0000;
			imm_q    <= 16'h0000;
			count_q  <= 3'd0;
			halted_q <= 1'b0;
		end else if (en && !halted_q) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			modrm_q  <= modrm_n;
			disp_q   <= disp_n;
			imm_q    <= imm_n;
			count_q  <= count_n;
			halted_q <= halted_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/x86mad_outreg.sv
`default_nettype none

module x86mad_outreg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire x86mad_pkg::rec_t  rec_in,
	input  wire logic              out_stall,
	output logic                   free,
	output logic                   out_valid,
	output x86mad_pkg::rec_t       rec_out
);
	import x86mad_pkg::*;

	logic valid_q;
	rec_t rec_q;

	// The slot can take a new record when empty or when its record leaves now.
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign rec_out   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/x86_mov_arith_byte_decoder.sv
// Byte-serial decoder for a subset of 8086 instructions: mov forms and the
// immediate arithmetic group.
// Input channel: in_valid / in_stall with code_byte, one request per code
// byte. A byte is taken at a clock edge where in_valid is high and in_stall
// is low. Output channel: out_valid / out_stall with one port per field of
// the decoded record; a record is taken where out_valid is high and
// out_stall is low.
// Throughput is one byte per cycle while the receiver does not stall. A
// byte waits in the input register until the output register is free and
// then steps the phase machine; the record of the byte that completes an
// instruction is loaded into the output register, which drives out_valid.
// An unknown opcode byte yields a record with status set and then halts the
// decoder: later bytes are consumed and dropped until reset.
// While the receiver stalls, the output register holds its record and the
// input register holds one byte; in_stall rises only when both are full.
// Reset (arst_n low) empties both registers and returns the decoder to
// waiting for an opcode byte.
`default_nettype none

module x86_mov_arith_byte_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  code_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [2:0]       operation,
	output logic [1:0]       form,
	output logic             wide,
	output logic             to_reg,
	output logic [1:0]       mode,
	output logic [2:0]       reg_sel,
	output logic [2:0]       rm_sel,
	output logic [15:0]      displacement,
	output logic [15:0]      immediate,
	output logic [2:0]       length,
	output logic [7:0]       first_byte
);
	import x86mad_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       adv;
	logic       emit;
	rec_t       rec_next;
	rec_t       rec_q;

	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= code_byte;
		end
	end

	x86mad_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.code_byte (byte_s1),
		.rec       (rec_next),
		.emit      (emit)
	);

	x86mad_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.rec_in    (rec_next),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.rec_out   (rec_q)
	);

	assign status       = rec_q.status;
	assign operation    = rec_q.operation;
	assign form         = rec_q.form;
	assign wide         = rec_q.wide;
	assign to_reg       = rec_q.to_reg;
	assign mode         = rec_q.mode;
	assign reg_sel      = rec_q.reg_sel;
	assign rm_sel       = rec_q.rm_sel;
	assign displacement = rec_q.displacement;
	assign immediate    = rec_q.immediate;
	assign length       = rec_q.length;
	assign first_byte   = rec_q.first_byte;

endmodule

`default_nettype wire

// File: dv/x86_mov_arith_byte_decoder_checker.sv
`timescale 1ns / 100ps

module x86_mov_arith_byte_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        status,
	input  logic [2:0]  operation,
	input  logic [1:0]  form,
	input  logic        wide,
	input  logic        to_reg,
	input  logic [1:0]  mode,
	input  logic [2:0]  reg_sel,
	input  logic [2:0]  rm_sel,
	input  logic [15:0] displacement,
	input  logic [15:0] immediate,
	input  logic [2:0]  length,
	input  logic [7:0]  first_byte,
	output int          failures,
	output int          pending,
	output int          checked
);
	import x86mad_pkg::*;

	localparam logic [7:0] MOV_RM_OPC      = 8'h88;
	localparam logic [7:0] MOV_IMM_REG_OPC = 8'hB0;
	localparam logic [7:0] MOV_IMM_RM_OPC  = 8'hC6;
	localparam logic [7:0] GROUP_OPC       = 8'h80;
	localparam int         REPORT_LIMIT    = 10;

	typedef enum logic [2:0] {
		AWAIT_OPCODE,
		AWAIT_MODRM,
		AWAIT_DISP_LO,
		AWAIT_DISP_HI,
		AWAIT_IMM_LO,
		AWAIT_IMM_HI
	} decode_step_t;

	decode_step_t step_st;
	logic [7:0]   opc_q;
	logic [7:0]   modrm_q;
	logic [15:0]  disp_q;
	logic [15:0]  imm_q;
	logic [2:0]   count_q;
	logic         halted_q;
	rec_t         expected_q[$];
	int           fail_count = 0;
	int           pending_n = 0;
	int           checked_n = 0;

	assign failures = fail_count;
	assign pending  = pending_n;
	assign checked  = checked_n;

	function automatic kind_t classify(input logic [7:0] op);
		if ((op & 8'hFC) == MOV_RM_OPC) return KIND_REGMEM;
		if ((op & 8'hF0) == MOV_IMM_REG_OPC) return KIND_IMMREG;
		if ((op & 8'hFE) == MOV_IMM_RM_OPC) return KIND_MOVIMM;
		if ((op & 8'hFC) == GROUP_OPC) return KIND_GROUP;
		return KIND_UNKNOWN;
	endfunction

	function automatic int disp_bytes(input logic [7:0] modrm);
		case (modrm[7:6])
			MOD_DISP8:  return 1;
			MOD_DISP16: return 2;
			MOD_MEM:    return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
			default:    return 0;
		endcase
	endfunction

	function automatic int imm_bytes(input logic [7:0] op);
		case (classify(op))
			KIND_IMMREG: return op[3] ? 2 : 1;
			KIND_MOVIMM: return op[0] ? 2 : 1;
			KIND_GROUP:  return (op == OPC_GROUP_W) ? 2 : 1;
			default:     return 0;
		endcase
	endfunction

	task automatic push_record();
		rec_t r;
		r              = '0;
		r.operation    = OPER_MOV;
		r.form         = FORM_IMM_RM;
		r.wide         = opc_q[0];
		r.mode         = modrm_q[7:6];
		r.reg_sel      = modrm_q[5:3];
		r.rm_sel       = modrm_q[2:0];
		r.displacement = disp_q;
		r.immediate    = imm_q;
		r.length       = count_q;
		r.first_byte   = opc_q;
		case (classify(opc_q))
			KIND_REGMEM: begin
				r.form   = FORM_REG_RM;
				r.to_reg = opc_q[1];
			end
			KIND_IMMREG: begin
				r.form    = FORM_IMM_REG;
				r.wide    = opc_q[3];
				r.to_reg  = 1'b1;
				r.mode    = 2'd0;
				r.rm_sel  = 3'd0;
				r.reg_sel = opc_q[2:0];
			end
			KIND_GROUP: begin
				case (modrm_q[5:3])
					GRP_ADD: r.operation = OPER_ADD;
					GRP_SUB: r.operation = OPER_SUB;
					GRP_CMP: r.operation = OPER_CMP;
					default: r.operation = OPER_OTHER;
				endcase
			end
			default: begin
			end
		endcase
		expected_q.push_back(r);
		step_st = AWAIT_OPCODE;
	endtask

	// Called once all displacement bytes are in, or right after the
	// addressing byte when there are none.
	task automatic operands_done();
		if (imm_bytes(opc_q) != 0) begin
			step_st = AWAIT_IMM_LO;
		end else begin
			push_record();
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		rec_t err;
		if (halted_q) return;
		if (count_q != COUNT_MAX) count_q++;
		case (step_st)
			AWAIT_MODRM: begin
				modrm_q = b;
				if (disp_bytes(b) != 0) begin
					step_st = AWAIT_DISP_LO;
				end else begin
					operands_done();
				end
			end
			AWAIT_DISP_LO: begin
				if (disp_bytes(modrm_q) == 2) begin
					disp_q  = {8'h00, b};
					step_st = AWAIT_DISP_HI;
				end else begin
					disp_q = {{8{b[7]}}, b};
					operands_done();
				end
			end
			AWAIT_DISP_HI: begin
				disp_q[15:8] = b;
				operands_done();
			end
			AWAIT_IMM_LO: begin
				if (imm_bytes(opc_q) == 2) begin
					imm_q   = {8'h00, b};
					step_st = AWAIT_IMM_HI;
				end else begin
					// Only the sign-extending group opcode widens a negative byte.
					imm_q = (opc_q == OPC_GROUP_SEXT) ? {{8{b[7]}}, b} : {8'h00, b};
					push_record();
				end
			end
			AWAIT_IMM_HI: begin
				imm_q[15:8] = b;
				push_record();
			end
			default: begin
				opc_q   = b;
				modrm_q = '0;
				disp_q  = '0;
				imm_q   = '0;
				count_q = 3'd1;
				case (classify(b))
					KIND_UNKNOWN: begin
						err            = '0;
						err.status     = 1'b1;
						err.length     = 3'd1;
						err.first_byte = b;
						expected_q.push_back(err);
						halted_q = 1'b1;
						step_st  = AWAIT_OPCODE;
					end
					KIND_IMMREG: step_st = AWAIT_IMM_LO;
					default:     step_st = AWAIT_MODRM;
				endcase
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got, input logic [7:0] opc);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("Mismatch in %s of record %0d (opcode %02h): expected %0h, got %0h",
					name, checked_n, opc, want, got);
			end
		end
	endtask

	task automatic compare_record();
		rec_t got;
		rec_t want;
		got = {status, operation, form, wide, to_reg, mode, reg_sel, rm_sel,
			displacement, immediate, length, first_byte};
		if (expected_q.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("Unexpected decoded record with first byte %02h", got.first_byte);
			end
			return;
		end
		want = expected_q.pop_front();
		check_field("status", 16'(want.status), 16'(got.status), want.first_byte);
		check_field("operation", 16'(want.operation), 16'(got.operation), want.first_byte);
		check_field("form", 16'(want.form), 16'(got.form), want.first_byte);
		check_field("wide", 16'(want.wide), 16'(got.wide), want.first_byte);
		check_field("to_reg", 16'(want.to_reg), 16'(got.to_reg), want.first_byte);
		check_field("mode", 16'(want.mode), 16'(got.mode), want.first_byte);
		check_field("reg_sel", 16'(want.reg_sel), 16'(got.reg_sel), want.first_byte);
		check_field("rm_sel", 16'(want.rm_sel), 16'(got.rm_sel), want.first_byte);
		check_field("displacement", want.displacement, got.displacement, want.first_byte);
		check_field("immediate", want.immediate, got.immediate, want.first_byte);
		check_field("length", 16'(want.length), 16'(got.length), want.first_byte);
		check_field("first_byte", 16'(want.first_byte), 16'(got.first_byte), want.first_byte);
		checked_n++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_st  = AWAIT_OPCODE;
			opc_q    = '0;
			modrm_q  = '0;
			disp_q   = '0;
			imm_q    = '0;
			count_q  = '0;
			halted_q = 1'b0;
			expected_q.delete();
		end else begin
			// A request accepted now can only show up as a record at a later edge.
			if (in_valid && !in_stall) begin
				decode_byte(code_byte);
			end
			if (out_valid && !out_stall) begin
				compare_record();
			end
		end
		pending_n = expected_q.size();
	end

endmodule

// File: dv/tb_x86_mov_arith_byte_decoder.sv
`timescale 1ns / 100ps

module tb_x86_mov_arith_byte_decoder;
	import x86mad_pkg::*;

	localparam int         N_DIRECTED      = 88;
	localparam int         N_RANDOM_BYTES  = 1750;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         DRAIN_CYCLES    = 10;
	localparam int         PROFILE_INSTRS  = 50;
	localparam logic [7:0] MOV_RM_OPC      = 8'h88;
	localparam logic [7:0] MOV_IMM_REG_OPC = 8'hB0;
	localparam logic [7:0] MOV_IMM_RM_OPC  = 8'hC6;
	localparam logic [7:0] GROUP_OPC       = 8'h80;

	localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
		8'h88, 8'hC1,
		8'h8B, 8'h1E, 8'h34, 8'h12,
		8'h89, 8'h47, 8'hF0,
		8'h8A, 8'h85, 8'hFF, 8'hFF,
		8'h88, 8'h00,
		8'h8B, 8'hFF,
		8'h89, 8'h06, 8'h00, 8'h00,
		8'h8A, 8'h80, 8'h00, 8'h80,
		8'hB0, 8'h00,
		8'hB7, 8'hFF,
		8'hB8, 8'h00, 8'h00,
		8'hBF, 8'hFF, 8'hFF,
		8'hBC, 8'h80, 8'h7F,
		8'hC6, 8'h06, 8'hCD, 8'hAB, 8'h80,
		8'hC7, 8'h86, 8'h01, 8'h80, 8'hFF, 8'h7F,
		8'hC6, 8'hF8, 8'h7F,
		8'hC7, 8'hC0, 8'h34, 8'h12,
		8'h80, 8'hC0, 8'hFF,
		8'h81, 8'h2E, 8'h78, 8'h56, 8'hFE, 8'hFF,
		8'h82, 8'hF8, 8'h80,
		8'h83, 8'hC8, 8'h80,
		8'h83, 8'h40, 8'h7F, 8'h7F,
		8'h83, 8'hD0, 8'hFF,
		8'h80, 8'h6D, 8'h80, 8'h01,
		8'h81, 8'hBF, 8'hFF, 8'h7F, 8'h00, 8'h80
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  code_byte = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        status;
	logic [2:0]  operation;
	logic [1:0]  form;
	logic        wide;
	logic        to_reg;
	logic [1:0]  mode;
	logic [2:0]  reg_sel;
	logic [2:0]  rm_sel;
	logic [15:0] displacement;
	logic [15:0] immediate;
	logic [2:0]  length;
	logic [7:0]  first_byte;
	int          failures;
	int          pending;
	int          checked;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          bytes_sent = 0;
	int          instr_count = 0;

	x86_mov_arith_byte_decoder i_dut (.*);

	x86_mov_arith_byte_decoder_checker i_checker (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Run exceeded %0d cycles", CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	// One request per code byte; valid is held until the byte is taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		code_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_random_instr();
		logic [7:0] op;
		logic [1:0] md;
		logic [2:0] rg;
		logic [2:0] rm;
		bit         has_modrm;
		int         n_disp;
		int         n_imm;
		has_modrm = 1'b1;
		case ($urandom_range(3))
			0: begin
				op    = MOV_RM_OPC | 8'($urandom_range(3));
				n_imm = 0;
			end
			1: begin
				op        = MOV_IMM_REG_OPC | 8'($urandom_range(15));
				has_modrm = 1'b0;
				n_imm     = op[3] ? 2 : 1;
			end
			2: begin
				op    = MOV_IMM_RM_OPC | 8'($urandom_range(1));
				n_imm = op[0] ? 2 : 1;
			end
			default: begin
				op    = GROUP_OPC | 8'($urandom_range(3));
				n_imm = (op == OPC_GROUP_W) ? 2 : 1;
			end
		endcase
		md = 2'($urandom_range(3));
		rg = 3'($urandom_range(7));
		rm = 3'($urandom_range(7));
		// Direct addressing is rare in uniform bytes, so push it along.
		if (md == MOD_MEM && $urandom_range(3) == 0) rm = RM_DIRECT;
		if (!has_modrm) begin
			n_disp = 0;
		end else if (md == MOD_DISP8) begin
			n_disp = 1;
		end else if (md == MOD_DISP16 || (md == MOD_MEM && rm == RM_DIRECT)) begin
			n_disp = 2;
		end else begin
			n_disp = 0;
		end
		send_byte(op);
		if (has_modrm) send_byte({md, rg, rm});
		repeat (n_disp + n_imm) send_byte(pick_byte());
		instr_count++;
	endtask

	initial begin
		logic [7:0] bad_opc;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_byte(DIRECTED_BYTES[i]);
		end

		while (bytes_sent < N_DIRECTED + N_RANDOM_BYTES) begin
			case ((instr_count / PROFILE_INSTRS) % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 76;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 76;
				end
				default: begin
					idle_pct  = 28;
					stall_pct = 28;
				end
			endcase
			send_random_instr();
		end

		// An unknown opcode halts the decoder for good, so it comes last,
		// followed by bytes that must be swallowed without a record.
		do begin
			bad_opc = 8'($urandom);
		end while ((bad_opc & 8'hFC) == MOV_RM_OPC || (bad_opc & 8'hF0) == MOV_IMM_REG_OPC ||
			(bad_opc & 8'hFE) == MOV_IMM_RM_OPC || (bad_opc & 8'hFC) == GROUP_OPC);
		send_byte(bad_opc);
		send_byte(MOV_IMM_REG_OPC);
		send_byte(pick_byte());
		repeat (4) send_byte(8'($urandom));
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0) begin
			$display("%0d decoded records never appeared", pending);
		end
		$display("Sent %0d code bytes forming %0d random instructions plus a directed set,",
			bytes_sent, instr_count);
		$display("under four idle/stall profiles; %0d records checked, halt on opcode %02h.",
			checked, bad_opc);
		if (failures == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
